[design/srv_pkg.sv]
// ---------------------------------------------------------------------------
// srv_pkg
// shared types and constants for the settings record validator
// ---------------------------------------------------------------------------
package srv_pkg;

  localparam int unsigned IdxW = 9;

  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
  localparam logic [7:0]  COMMIT_MARK = 8'hA5;
  localparam logic [7:0]  VERSION_ONE = 8'h01;

  localparam logic [7:0] MAGIC_BYTES [4] = '{8'h53, 8'h33, 8'h35, 8'h43};

  localparam logic [IdxW-1:0] IDX_MAGIC_END = 9'd4;
  localparam logic [IdxW-1:0] IDX_VERSION   = 9'd4;
  localparam logic [IdxW-1:0] IDX_SEQ_LO    = 9'd8;
  localparam logic [IdxW-1:0] IDX_SEQ_END   = 9'd12;
  localparam logic [IdxW-1:0] IDX_MAC_LO    = 9'd16;
  localparam logic [IdxW-1:0] IDX_MAC_END   = 9'd22;
  localparam logic [IdxW-1:0] IDX_PORT_LO   = 9'd22;
  localparam logic [IdxW-1:0] IDX_PORT_HI   = 9'd23;
  localparam logic [IdxW-1:0] IDX_HOST_LO   = 9'd24;
  localparam logic [IdxW-1:0] IDX_WORKER_LO = 9'd120;
  localparam logic [IdxW-1:0] IDX_PASS_LO   = 9'd248;
  localparam logic [IdxW-1:0] IDX_PASS_END  = 9'd312;
  localparam logic [IdxW-1:0] IDX_CRC_END   = 9'd504;
  localparam logic [IdxW-1:0] IDX_SUM_END   = 9'd508;
  localparam logic [IdxW-1:0] IDX_LAST      = 9'd511;

  typedef enum logic [3:0] {
    ERR_OK       = 4'd0,
    ERR_MAGIC    = 4'd1,
    ERR_VERSION  = 4'd2,
    ERR_COMMIT   = 4'd3,
    ERR_CRC      = 4'd4,
    ERR_MAC      = 4'd5,
    ERR_PORT     = 4'd6,
    ERR_HOST     = 4'd7,
    ERR_WORKER   = 4'd8,
    ERR_PASSWORD = 4'd9
  } err_e;

  typedef struct packed {
    logic [15:0] port;
    logic [31:0] sequence_res;
    err_e        error_code;
    logic        record_ok;
  } result_t;

endpackage

[design/srv_crc_step.sv]
// ---------------------------------------------------------------------------
// srv_crc_step
// one byte of reflected crc-32, eight bit steps unrolled
// ---------------------------------------------------------------------------
module srv_crc_step
  import srv_pkg::*;
(
  input  logic [31:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [31:0] crc_o
);

  always_comb begin
    logic [31:0] c;
    c = crc_i ^ {24'd0, byte_i};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    crc_o = c;
  end

endmodule

[design/srv_checker.sv]
// ---------------------------------------------------------------------------
// srv_checker
// per-record state, field checks and the verdict at the last byte
// ---------------------------------------------------------------------------
module srv_checker
  import srv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [7:0]  byte_i,
  input  logic        restart_i,
  output logic        last_o,
  output result_t     res_o
);

  logic [IdxW-1:0] idx_q, idx_d, idx;
  logic [31:0]     crc_q, crc_d, crc_cur, crc_upd;
  logic [31:0]     sum_q, sum_d, sum_cur;
  logic [31:0]     seq_q, seq_d, seq_cur;
  logic [15:0]     port_q, port_d, port_cur;
  logic [1:0]      mac_q, mac_d, mac_cur;
  logic [1:0]      txt_q [3];
  logic [1:0]      txt_d [3];
  logic [1:0]      txt_cur [3];
  logic            cset_q, cset_d, cset_cur;
  err_e            ff_q, ff_d, ff_cur;
  logic            clr;
  logic            forbidden, host_ok;
  logic [1:0]      fsel;
  logic            in_text;
  err_e            code;

  srv_crc_step u_crc (
    .crc_i  (crc_cur),
    .byte_i (byte_i),
    .crc_o  (crc_upd)
  );

  assign clr = restart_i || (idx_q == '0);
  assign idx = restart_i ? '0 : idx_q;

  assign forbidden = (byte_i < 8'd32) || (byte_i > 8'd126) ||
                     (byte_i == 8'h22) || (byte_i == 8'h5C);
  assign host_ok = (byte_i >= 8'h61 && byte_i <= 8'h7A) ||
                   (byte_i >= 8'h41 && byte_i <= 8'h5A) ||
                   (byte_i >= 8'h30 && byte_i <= 8'h39) ||
                   (byte_i == 8'h2E) || (byte_i == 8'h2D);

  always_comb begin
    crc_cur  = clr ? 32'hFFFFFFFF : crc_q;
    sum_cur  = clr ? 32'd0 : sum_q;
    seq_cur  = clr ? 32'd0 : seq_q;
    port_cur = clr ? 16'd0 : port_q;
    mac_cur  = clr ? 2'd0 : mac_q;
    cset_cur = clr ? 1'b0 : cset_q;
    ff_cur   = clr ? ERR_OK : ff_q;
    for (int f = 0; f < 3; f++) begin
      txt_cur[f] = clr ? 2'd0 : txt_q[f];
    end

    crc_d  = (idx < IDX_CRC_END) ? crc_upd : crc_cur;
    sum_d  = sum_cur;
    seq_d  = seq_cur;
    port_d = port_cur;
    mac_d  = mac_cur;
    cset_d = cset_cur;
    ff_d   = ff_cur;
    for (int f = 0; f < 3; f++) begin
      txt_d[f] = txt_cur[f];
    end

    if (idx < IDX_MAGIC_END) begin
      if (byte_i != MAGIC_BYTES[idx[1:0]] && ff_cur == ERR_OK) begin
        ff_d = ERR_MAGIC;
      end
    end else if (idx == IDX_VERSION) begin
      if (byte_i != VERSION_ONE && ff_cur == ERR_OK) begin
        ff_d = ERR_VERSION;
      end
    end

    if (idx >= IDX_SEQ_LO && idx < IDX_SEQ_END) begin
      seq_d = seq_cur | ({24'd0, byte_i} << {idx[1:0], 3'd0});
    end

    if (idx >= IDX_MAC_LO && idx < IDX_MAC_END) begin
      if (byte_i != 8'd0) begin
        mac_d[0] = 1'b1;
      end
      if (idx == IDX_MAC_LO && byte_i[0]) begin
        mac_d[1] = 1'b1;
      end
    end

    if (idx == IDX_PORT_LO) begin
      port_d[7:0] = port_cur[7:0] | byte_i;
    end else if (idx == IDX_PORT_HI) begin
      port_d[15:8] = port_cur[15:8] | byte_i;
    end

    if (idx >= IDX_CRC_END && idx < IDX_SUM_END) begin
      sum_d = sum_cur | ({24'd0, byte_i} << {idx[1:0], 3'd0});
    end

    in_text = 1'b1;
    if (idx >= IDX_HOST_LO && idx < IDX_WORKER_LO) begin
      fsel = 2'd0;
    end else if (idx >= IDX_WORKER_LO && idx < IDX_PASS_LO) begin
      fsel = 2'd1;
    end else if (idx >= IDX_PASS_LO && idx < IDX_PASS_END) begin
      fsel = 2'd2;
    end else begin
      fsel    = 2'd0;
      in_text = 1'b0;
    end

    // text field: stop looking once nul seen or already bad
    if (in_text && txt_cur[fsel] == 2'd0) begin
      if (byte_i == 8'd0) begin
        txt_d[fsel] = 2'b01;
      end else if (forbidden) begin
        txt_d[fsel] = 2'b10;
      end else if (fsel == 2'd0 && !host_ok) begin
        cset_d = 1'b1;
      end
    end

    if (ff_d != ERR_OK) begin
      code = ff_d;
    end else if (byte_i != COMMIT_MARK) begin
      code = ERR_COMMIT;
    end else if (~crc_d != sum_d) begin
      code = ERR_CRC;
    end else if (!mac_d[0] || mac_d[1]) begin
      code = ERR_MAC;
    end else if (port_d == 16'd0) begin
      code = ERR_PORT;
    end else if (txt_d[0] != 2'b01) begin
      code = ERR_HOST;
    end else if (txt_d[1] != 2'b01) begin
      code = ERR_WORKER;
    end else if (txt_d[2] != 2'b01) begin
      code = ERR_PASSWORD;
    end else if (cset_d) begin
      code = ERR_HOST;
    end else begin
      code = ERR_OK;
    end

    idx_d = idx + 9'd1;
  end

  assign last_o             = (idx == IDX_LAST);
  assign res_o.record_ok    = (code == ERR_OK);
  assign res_o.error_code   = code;
  assign res_o.sequence_res = seq_d;
  assign res_o.port         = port_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      crc_q  <= 32'hFFFFFFFF;
      sum_q  <= '0;
      seq_q  <= '0;
      port_q <= '0;
      mac_q  <= '0;
      cset_q <= 1'b0;
      ff_q   <= ERR_OK;
      for (int f = 0; f < 3; f++) begin
        txt_q[f] <= '0;
      end
    end else if (en_i) begin
      idx_q  <= idx_d;
      crc_q  <= crc_d;
      sum_q  <= sum_d;
      seq_q  <= seq_d;
      port_q <= port_d;
      mac_q  <= mac_d;
      cset_q <= cset_d;
      ff_q   <= ff_d;
      for (int f = 0; f < 3; f++) begin
        txt_q[f] <= txt_d[f];
      end
    end
  end

endmodule

[design/settings_record_validator_unit.sv]
// ---------------------------------------------------------------------------
// settings_record_validator_unit
// checks a 512-byte settings record streamed one byte per beat
// ---------------------------------------------------------------------------
// verdict path: byte 511 is registered at the input, then its verdict is registered at the output
// throughput: 1 byte per cycle unless a held verdict stalls, set by the combinational bytewise crc update
// a held verdict stalls input only when the next record's last byte arrives
// reset: byte index 0, crc preset all ones, all checks cleared, no beat out
// ---------------------------------------------------------------------------
module settings_record_validator_unit
  import srv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // record_ok, error_code[3:0],
                                      // sequence_res[31:0], port[15:0], zero pad
);

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_restart_q;
  logic        out_valid_q, out_valid_d;
  result_t     out_res_q;
  logic        is_last;
  logic        proc;
  result_t     res;

  srv_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (proc),
    .byte_i    (in_byte_q),
    .restart_i (in_restart_q),
    .last_o    (is_last),
    .res_o     (res)
  );

  assign proc = in_valid_q && (!is_last || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc;

  always_comb begin
    out_valid_d = out_valid_q;
    if (proc && is_last) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q    <= s_axis_tdata;
      in_restart_q <= s_axis_tuser;
    end
    if (proc && is_last) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'd0, out_res_q};

endmodule

[tb/testbench.sv]
// ---------------------------------------------------------------------------
// testbench
// streams 512-byte settings records into the validator and checks each
// verdict beat against a byte-level model of the record checks. a table of
// directed records covers every failure code, the extremes, restarts and
// back-to-back records; random records, bit flips and noise follow while
// valid and ready gaps change from phase to phase
// ---------------------------------------------------------------------------
module testbench;
  import srv_pkg::*;

  typedef enum int {
    K_GOOD, K_EXTREMES, K_ZEROS, K_MAGIC0, K_MAGIC3, K_VERSION, K_MAGIC_VERSION,
    K_COMMIT, K_CRC, K_MAC_ZERO, K_MAC_MCAST, K_PORT_ZERO, K_HOST_NO_NUL,
    K_HOST_QUOTE, K_HOST_CHARSET, K_CHARSET_WORKER, K_WORKER_BSLASH,
    K_WORKER_HIGH, K_PASS_CTRL, K_PASS_DEL, K_PASS_NO_NUL, K_FLIP
  } rec_kind_e;

  typedef struct {
    rec_kind_e kind;
    int        cut;
    bit        rs0;
    bit        pin;
    err_e      code;
  } rec_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // data_byte
  logic        s_axis_tuser;   // restart
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;   // record_ok, error_code[3:0], sequence_res[31:0],
                               // port[15:0], zero pad

  logic [8:0]  rec_idx;
  logic [31:0] crc_run;
  logic [31:0] sum_word;
  logic [31:0] seq_word;
  logic [15:0] port_acc;
  logic        mac_nz;
  logic        mac_mc;
  logic [2:0]  txt_nul;
  logic [2:0]  txt_bad;
  logic        host_set_bad;
  err_e        hdr_fail;

  result_t     pending_verdicts [$];
  int          bad_verdicts;
  int          src_idle_pct;
  int          snk_idle_pct;

  logic [7:0]  rec_buf [512];
  int          host_nul;
  int          worker_nul;
  int          pass_nul;

  rec_row_t directed_plan [25] = '{
    '{K_GOOD,           0,   1'b0, 1'b1, ERR_OK},
    '{K_GOOD,           0,   1'b0, 1'b1, ERR_OK},
    '{K_EXTREMES,       0,   1'b1, 1'b1, ERR_OK},
    '{K_ZEROS,          0,   1'b1, 1'b1, ERR_OK},
    '{K_MAGIC0,         0,   1'b1, 1'b1, ERR_MAGIC},
    '{K_MAGIC3,         0,   1'b1, 1'b1, ERR_MAGIC},
    '{K_VERSION,        0,   1'b1, 1'b1, ERR_VERSION},
    '{K_MAGIC_VERSION,  0,   1'b1, 1'b1, ERR_MAGIC},
    '{K_COMMIT,         0,   1'b1, 1'b1, ERR_COMMIT},
    '{K_CRC,            0,   1'b1, 1'b1, ERR_CRC},
    '{K_MAC_ZERO,       0,   1'b1, 1'b1, ERR_MAC},
    '{K_MAC_MCAST,      0,   1'b1, 1'b1, ERR_MAC},
    '{K_PORT_ZERO,      0,   1'b1, 1'b1, ERR_PORT},
    '{K_HOST_NO_NUL,    0,   1'b1, 1'b1, ERR_HOST},
    '{K_HOST_QUOTE,     0,   1'b1, 1'b1, ERR_HOST},
    '{K_HOST_CHARSET,   0,   1'b1, 1'b1, ERR_HOST},
    '{K_CHARSET_WORKER, 0,   1'b1, 1'b1, ERR_WORKER},
    '{K_WORKER_BSLASH,  0,   1'b1, 1'b1, ERR_WORKER},
    '{K_WORKER_HIGH,    0,   1'b1, 1'b1, ERR_WORKER},
    '{K_PASS_CTRL,      0,   1'b1, 1'b1, ERR_PASSWORD},
    '{K_PASS_DEL,       0,   1'b1, 1'b1, ERR_PASSWORD},
    '{K_PASS_NO_NUL,    0,   1'b1, 1'b1, ERR_PASSWORD},
    '{K_GOOD,           200, 1'b1, 1'b0, ERR_OK},
    '{K_GOOD,           511, 1'b0, 1'b0, ERR_OK},
    '{K_FLIP,           0,   1'b1, 1'b0, ERR_OK}
  };

  settings_record_validator_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    int k;
    r = c ^ {24'd0, b};
    for (k = 0; k < 8; k++) r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
    return r;
  endfunction

  function automatic bit text_forbidden(logic [7:0] b);
    return b < 8'd32 || b > 8'd126 || b == 8'h22 || b == 8'h5C;
  endfunction

  function automatic bit host_allowed(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h30 && b <= 8'h39) || b == 8'h2E || b == 8'h2D;
  endfunction

  function automatic void clear_model();
    rec_idx      = '0;
    crc_run      = '1;
    sum_word     = '0;
    seq_word     = '0;
    port_acc     = '0;
    mac_nz       = 1'b0;
    mac_mc       = 1'b0;
    txt_nul      = '0;
    txt_bad      = '0;
    host_set_bad = 1'b0;
    hdr_fail     = ERR_OK;
  endfunction

  function automatic void scan_text(int f, logic [7:0] b);
    if (txt_nul[f] || txt_bad[f]) return;
    if (b == 8'd0) txt_nul[f] = 1'b1;
    else if (text_forbidden(b)) txt_bad[f] = 1'b1;
    else if (f == 0 && !host_allowed(b)) host_set_bad = 1'b1;
  endfunction

  function automatic bit text_fails(int f);
    return !txt_nul[f] || txt_bad[f];
  endfunction

  // updates the record state for one accepted byte, queues the verdict at byte 511
  function automatic void model_byte(logic [7:0] b, logic rs, bit pin, err_e pin_code);
    logic [8:0] i;
    err_e       code;
    result_t    v;
    if (rs || rec_idx == '0) clear_model();
    i = rec_idx;
    if (i < IDX_CRC_END) crc_run = crc_step(crc_run, b);
    if (i < IDX_MAGIC_END) begin
      if (b != MAGIC_BYTES[i[1:0]] && hdr_fail == ERR_OK) hdr_fail = ERR_MAGIC;
    end else if (i == IDX_VERSION) begin
      if (b != VERSION_ONE && hdr_fail == ERR_OK) hdr_fail = ERR_VERSION;
    end else if (i >= IDX_SEQ_LO && i < IDX_SEQ_END) begin
      seq_word[8*(i-IDX_SEQ_LO) +: 8] = b;
    end else if (i >= IDX_MAC_LO && i < IDX_MAC_END) begin
      if (b != 8'd0) mac_nz = 1'b1;
      if (i == IDX_MAC_LO && b[0]) mac_mc = 1'b1;
    end else if (i == IDX_PORT_LO || i == IDX_PORT_HI) begin
      port_acc[8*(i-IDX_PORT_LO) +: 8] = b;
    end else if (i >= IDX_HOST_LO && i < IDX_WORKER_LO) begin
      scan_text(0, b);
    end else if (i >= IDX_WORKER_LO && i < IDX_PASS_LO) begin
      scan_text(1, b);
    end else if (i >= IDX_PASS_LO && i < IDX_PASS_END) begin
      scan_text(2, b);
    end else if (i >= IDX_CRC_END && i < IDX_SUM_END) begin
      sum_word[8*(i-IDX_CRC_END) +: 8] = b;
    end
    rec_idx = i + 9'd1;
    if (i != IDX_LAST) return;
    if (hdr_fail != ERR_OK) code = hdr_fail;
    else if (b != COMMIT_MARK) code = ERR_COMMIT;
    else if (~crc_run != sum_word) code = ERR_CRC;
    else if (!mac_nz || mac_mc) code = ERR_MAC;
    else if (port_acc == '0) code = ERR_PORT;
    else if (text_fails(0)) code = ERR_HOST;
    else if (text_fails(1)) code = ERR_WORKER;
    else if (text_fails(2)) code = ERR_PASSWORD;
    else if (host_set_bad) code = ERR_HOST;
    else code = ERR_OK;
    if (pin) code = pin_code;
    v.record_ok    = (code == ERR_OK);
    v.error_code   = code;
    v.sequence_res = seq_word;
    v.port         = port_acc;
    pending_verdicts.push_back(v);
  endfunction

  function automatic void check_verdict(result_t got);
    result_t want;
    if (pending_verdicts.size() == 0) begin
      bad_verdicts++;
      if (bad_verdicts <= 10)
        $display("unexpected verdict beat: ok=%0b code=%0d seq=%h port=%h",
                 got.record_ok, got.error_code, got.sequence_res, got.port);
      return;
    end
    want = pending_verdicts.pop_front();
    if (got.record_ok !== want.record_ok || got.error_code !== want.error_code ||
        got.sequence_res !== want.sequence_res || got.port !== want.port) begin
      bad_verdicts++;
      if (bad_verdicts <= 10)
        $display("verdict mismatch: exp ok=%0b code=%0d seq=%h port=%h,",
                 want.record_ok, want.error_code, want.sequence_res, want.port,
                 " got ok=%0b code=%0d seq=%h port=%h",
                 got.record_ok, got.error_code, got.sequence_res, got.port);
    end
  endfunction

  function automatic logic [7:0] host_char();
    int r;
    r = $urandom_range(63);
    if (r < 26) return 8'h61 + 8'(r);
    if (r < 52) return 8'h41 + 8'(r - 26);
    if (r < 62) return 8'h30 + 8'(r - 52);
    return (r == 62) ? 8'h2E : 8'h2D;
  endfunction

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    do c = 8'($urandom_range(126, 32)); while (c == 8'h22 || c == 8'h5C);
    return c;
  endfunction

  // printable but outside the host character set
  function automatic logic [7:0] odd_host_char();
    logic [7:0] c;
    do c = 8'($urandom_range(126, 33)); while (text_forbidden(c) || host_allowed(c));
    return c;
  endfunction

  function automatic void seal_checksum();
    logic [31:0] c;
    int j;
    c = '1;
    for (j = 0; j < 504; j++) c = crc_step(c, rec_buf[j]);
    c = ~c;
    for (j = 0; j < 4; j++) rec_buf[504 + j] = c[8*j +: 8];
  endfunction

  function automatic void build_record(rec_kind_e kind);
    int j;
    int p;
    int hl;
    int wl;
    int pl;
    logic [7:0] v;
    for (j = 0; j < 512; j++) rec_buf[j] = 8'($urandom_range(255));
    for (j = 0; j < 4; j++) rec_buf[j] = MAGIC_BYTES[j];
    rec_buf[IDX_VERSION] = VERSION_ONE;
    rec_buf[IDX_MAC_LO] = rec_buf[IDX_MAC_LO] & 8'hFE;
    if ((rec_buf[16] | rec_buf[17] | rec_buf[18] | rec_buf[19] | rec_buf[20] |
         rec_buf[21]) == 8'd0) rec_buf[17] = 8'h01;
    if ({rec_buf[23], rec_buf[22]} == 16'd0) rec_buf[22] = 8'h01;
    case (kind)
      K_EXTREMES: begin
        hl = 95; wl = 127; pl = 63;
      end
      K_ZEROS: begin
        hl = 0; wl = 0; pl = 0;
      end
      default: begin
        hl = $urandom_range(95); wl = $urandom_range(127); pl = $urandom_range(63);
      end
    endcase
    host_nul   = IDX_HOST_LO + hl;
    worker_nul = IDX_WORKER_LO + wl;
    pass_nul   = IDX_PASS_LO + pl;
    for (j = IDX_HOST_LO; j < host_nul; j++) rec_buf[j] = host_char();
    for (j = IDX_WORKER_LO; j < worker_nul; j++) rec_buf[j] = text_char();
    for (j = IDX_PASS_LO; j < pass_nul; j++) rec_buf[j] = text_char();
    rec_buf[host_nul]   = 8'h00;
    rec_buf[worker_nul] = 8'h00;
    rec_buf[pass_nul]   = 8'h00;
    rec_buf[IDX_LAST]   = COMMIT_MARK;

    case (kind)
      K_EXTREMES: begin
        for (j = 5; j < 24; j++) rec_buf[j] = 8'hFF;
        rec_buf[IDX_MAC_LO] = 8'hFE;
        for (j = IDX_PASS_END; j < 511; j++) rec_buf[j] = 8'hFF;
      end
      K_ZEROS: begin
        for (j = 5; j < 511; j++) rec_buf[j] = 8'h00;
        rec_buf[21] = 8'h01;
        rec_buf[23] = 8'h01;
      end
      K_MAGIC0: rec_buf[0] = rec_buf[0] ^ 8'($urandom_range(255, 1));
      K_MAGIC3: rec_buf[3] = rec_buf[3] ^ 8'($urandom_range(255, 1));
      K_VERSION, K_MAGIC_VERSION: begin
        v = 8'($urandom_range(255));
        rec_buf[IDX_VERSION] = (v == VERSION_ONE) ? 8'h00 : v;
        if (kind == K_MAGIC_VERSION) begin
          p = $urandom_range(3);
          rec_buf[p] = rec_buf[p] ^ 8'($urandom_range(255, 1));
        end
      end
      K_COMMIT: begin
        v = 8'($urandom_range(255));
        rec_buf[IDX_LAST] = (v == COMMIT_MARK) ? 8'h00 : v;
      end
      K_MAC_ZERO: for (j = IDX_MAC_LO; j < IDX_MAC_END; j++) rec_buf[j] = 8'h00;
      K_MAC_MCAST: rec_buf[IDX_MAC_LO] = rec_buf[IDX_MAC_LO] | 8'h01;
      K_PORT_ZERO: begin
        rec_buf[IDX_PORT_LO] = 8'h00;
        rec_buf[IDX_PORT_HI] = 8'h00;
      end
      K_HOST_NO_NUL:
        for (j = IDX_HOST_LO; j < IDX_WORKER_LO; j++) rec_buf[j] = host_char();
      K_HOST_QUOTE:
        rec_buf[IDX_HOST_LO + $urandom_range(host_nul - IDX_HOST_LO)] = 8'h22;
      K_HOST_CHARSET, K_CHARSET_WORKER: begin
        if (host_nul == IDX_HOST_LO) begin
          rec_buf[IDX_HOST_LO]     = odd_host_char();
          rec_buf[IDX_HOST_LO + 1] = 8'h00;
        end else begin
          p = IDX_HOST_LO + $urandom_range(host_nul - IDX_HOST_LO - 1);
          rec_buf[p] = odd_host_char();
        end
        if (kind == K_CHARSET_WORKER)
          rec_buf[IDX_WORKER_LO + $urandom_range(worker_nul - IDX_WORKER_LO)] = 8'h5C;
      end
      K_WORKER_BSLASH:
        rec_buf[IDX_WORKER_LO + $urandom_range(worker_nul - IDX_WORKER_LO)] = 8'h5C;
      K_WORKER_HIGH:
        rec_buf[IDX_WORKER_LO + $urandom_range(worker_nul - IDX_WORKER_LO)] =
          8'($urandom_range(255, 127));
      K_PASS_CTRL:
        rec_buf[IDX_PASS_LO + $urandom_range(pass_nul - IDX_PASS_LO)] =
          8'($urandom_range(31, 1));
      K_PASS_DEL:
        rec_buf[IDX_PASS_LO + $urandom_range(pass_nul - IDX_PASS_LO)] = 8'h7F;
      K_PASS_NO_NUL:
        for (j = IDX_PASS_LO; j < IDX_PASS_END; j++) rec_buf[j] = text_char();
      K_FLIP: begin
        p = $urandom_range(511);
        rec_buf[p] = rec_buf[p] ^ (8'h01 << $urandom_range(7));
      end
      default: ;
    endcase

    if (kind == K_CRC) begin
      seal_checksum();
      p = IDX_CRC_END + $urandom_range(3);
      rec_buf[p] = rec_buf[p] ^ 8'($urandom_range(255, 1));
    end else if (kind != K_FLIP || $urandom_range(1) == 1) begin
      seal_checksum();
    end
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic rs, input bit pin,
                           input err_e pin_code);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= rs;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    model_byte(b, rs, pin, pin_code);
  endtask

  // an optional aborted prefix, then the whole record
  task automatic send_record(input rec_row_t row);
    int j;
    build_record(row.kind);
    for (j = 0; j < row.cut; j++)
      push_byte(rec_buf[j], (j == 0) ? row.rs0 : 1'b0, 1'b0, ERR_OK);
    for (j = 0; j < 512; j++)
      push_byte(rec_buf[j], (j == 0) ? (row.cut > 0 || row.rs0) : 1'b0,
                row.pin, row.code);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) check_verdict(result_t'(m_axis_tdata[52:0]));
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int n;
    int j;
    int len;
    rec_row_t row;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tuser  = 1'b0;
    bad_verdicts  = 0;
    src_idle_pct  = 6;
    snk_idle_pct  = 78;
    clear_model();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_plan[r]) send_record(directed_plan[r]);

    for (n = 0; n < 48; n++) begin
      if (n == 16) begin
        src_idle_pct = 78;
        snk_idle_pct = 6;
      end
      if (n == 32) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      // stray bytes with the odd restart
      if ($urandom_range(4) == 0) begin
        len = $urandom_range(300, 1);
        for (j = 0; j < len; j++)
          push_byte(8'($urandom_range(255)), $urandom_range(19) == 0, 1'b0, ERR_OK);
      end
      row.kind = ($urandom_range(1) == 1) ? K_GOOD : rec_kind_e'($urandom_range(K_FLIP));
      row.cut  = ($urandom_range(4) == 0) ? $urandom_range(511, 1) : 0;
      row.rs0  = (rec_idx != '0) || ($urandom_range(1) == 1);
      row.pin  = 1'b0;
      row.code = ERR_OK;
      send_record(row);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (bad_verdicts == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
